// ===== design/tsr_pkg.sv =====
// Shared constants for the TIFF sample to RGBA8 unit.
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

  // Default sizes
  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned COORD_BITS_DEF    = 16;

  // Field widths
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned PIDX_W    = 8;
  localparam int unsigned PCOL_W    = 16;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned ENTRY_W   = 3 * CHAN_W;
  localparam int unsigned IN_DATA_W = SAMPLE_W + PIDX_W + 3 * PCOL_W;
  localparam int unsigned OUT_DATA_W = 4 * CHAN_W;
  localparam int unsigned OUT_USER_W = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned DIM_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // Pixel modes
  localparam logic [MODE_W-1:0] MODE_BILEVEL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GRAY8    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RGB      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RGBA     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PALETTE4 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PALETTE8 = 3'd5;

  // Input item kinds
  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_PALETTE = 1'b1;

  localparam logic [CHAN_W-1:0] CHAN_FULL  = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_EMPTY = 8'h00;
  localparam logic [3:0]        NIBBLE_MASK = 4'hF;

endpackage

`default_nettype wire

// ===== design/tsr_palette.sv =====
// Colour palette store: one write port, one registered read port, index wrap.
`timescale 1ns / 1ps
`default_nettype none

module tsr_palette #(
  parameter int unsigned DEPTH = tsr_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [tsr_pkg::PIDX_W-1:0]   wr_idx_i,
  input  wire logic [tsr_pkg::ENTRY_W-1:0]  wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [tsr_pkg::PIDX_W-1:0]   rd_idx_i,
  output logic      [tsr_pkg::ENTRY_W-1:0]  rd_data_o
);
  import tsr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;

  // Reduce an 8-bit index modulo the depth by restoring subtraction.
  function automatic logic [AW-1:0] wrap_idx(input logic [PIDX_W-1:0] idx);
    logic [15:0] v;
    v = {8'b0, idx};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (16'(DEPTH) << k)) begin
        v = v - (16'(DEPTH) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  assign wr_addr = wrap_idx(wr_idx_i);
  assign rd_addr = wrap_idx(rd_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ===== design/tiff_samples_to_rgba8_unit.sv =====
// Top level: decodes TIFF sample bytes into a stream of RGBA8 pixels.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+---------------------------------
//  s_axis    | in  | s_axis_tvalid_i/tready_o     | tdata: sample, pal idx, r, g, b
//            |     |                              | tuser: cmd
//  m_axis    | out | m_axis_tvalid_o/tready_i     | tdata: red, green, blue, alpha
//            |     |                              | tuser: end_of_row, end_of_image
//            |     |                              | tlast: last_in_run
//  cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// The work register emits one pixel per cycle into the output register unless the output
// stalls. An item makes up to 8 pixels for bilevel, up to 2 for palette4 and at most 1
// otherwise (palette writes and partial RGB/RGBA channel bytes make none).
// The next item enters in the cycle the current one finishes.
// Palette reads go through the registered memory port, loaded with the output register.
// Reset clears control state and counters; palette contents are undefined until written.
// A stalled output holds the pixel and the work register; input is accepted again
// as soon as the work register drains.
`timescale 1ns / 1ps
`default_nettype none

module tiff_samples_to_rgba8_unit #(
  parameter int unsigned PALETTE_DEPTH = tsr_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned COORD_BITS    = tsr_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // tdata: sample_byte[7:0], palette_index[15:8], palette_red[31:16],
  //        palette_green[47:32], palette_blue[63:48]
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [tsr_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: cmd[0]
  input  wire logic                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic      [tsr_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // tuser: end_of_row[0], end_of_image[1]
  output logic      [tsr_pkg::OUT_USER_W-1:0]  m_axis_tuser_o,
  output logic                                 m_axis_tlast_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tsr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tsr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tsr_pkg::*;

  localparam int unsigned CW = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;

  // Configuration
  logic [MODE_W-1:0] mode_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;

  // Work register
  logic                a_valid_q;
  logic                a_cmd_q;
  logic [SAMPLE_W-1:0] a_byte_q;
  logic [PIDX_W-1:0]   a_pidx_q;
  logic [ENTRY_W-1:0]  a_entry_q;
  logic [2:0]          a_pos_q, a_pos_d;

  // Decode state
  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [1:0]            slot_q, slot_d;
  logic [ENTRY_W-1:0]    pend_q, pend_d;

  // Output register
  logic                  o_valid_q;
  logic                  o_pal_q;
  logic [OUT_DATA_W-1:0] o_pix_q;
  logic                  o_eor_q;
  logic                  o_eoi_q;
  logic                  o_last_q;

  logic                  out_free;
  logic                  fire;
  logic                  a_done;
  logic                  emit;
  logic                  done;
  logic                  pix_pal;
  logic [OUT_DATA_W-1:0] pix;
  logic [PIDX_W-1:0]     pal_rd_idx;
  logic                  eor;
  logic                  eoi;
  logic [CW-1:0]         col_next;
  logic [CW-1:0]         row_next;
  logic [CHAN_W-1:0]     bw;
  logic [ENTRY_W-1:0]    pal_data;
  logic                  in_accept;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !o_valid_q || m_axis_tready_i;

  assign col_next = CW'(col_q) + CW'(1);
  assign row_next = CW'(row_q) + CW'(1);
  assign eor      = col_next >= CW'(width_q);
  assign eoi      = eor && (row_next >= CW'(height_q));

  assign bw = a_byte_q[~a_pos_q] ? CHAN_FULL : CHAN_EMPTY;

  always_comb begin
    emit       = 1'b0;
    done       = 1'b1;
    pix_pal    = 1'b0;
    pix        = {CHAN_FULL, a_byte_q, a_byte_q, a_byte_q};
    pal_rd_idx = a_byte_q;
    a_pos_d    = a_pos_q + 3'd1;
    slot_d     = slot_q;
    pend_d     = pend_q;
    if (a_cmd_q == CMD_SAMPLE) begin
      case (mode_q)
        MODE_BILEVEL: begin
          emit = 1'b1;
          pix  = {CHAN_FULL, bw, bw, bw};
          done = eor || (a_pos_q == 3'd7);
        end
        MODE_GRAY8: begin
          emit = 1'b1;
        end
        MODE_RGB, MODE_RGBA: begin
          if (slot_q >= ((mode_q == MODE_RGB) ? 2'd2 : 2'd3)) begin
            emit   = 1'b1;
            slot_d = 2'd0;
            if (mode_q == MODE_RGB) begin
              pix = {CHAN_FULL, a_byte_q, pend_q[15:8], pend_q[23:16]};
            end else begin
              pix = {a_byte_q, pend_q[7:0], pend_q[15:8], pend_q[23:16]};
            end
          end else begin
            slot_d = slot_q + 2'd1;
            case (slot_q)
              2'd0:    pend_d[23:16] = a_byte_q;
              2'd1:    pend_d[15:8]  = a_byte_q;
              default: pend_d[7:0]   = a_byte_q;
            endcase
          end
        end
        MODE_PALETTE4: begin
          emit       = 1'b1;
          pix_pal    = 1'b1;
          pal_rd_idx = a_pos_q[0] ? {4'b0, a_byte_q[3:0] & NIBBLE_MASK}
                                  : {4'b0, a_byte_q[7:4]};
          done       = eor || a_pos_q[0];
        end
        MODE_PALETTE8: begin
          emit    = 1'b1;
          pix_pal = 1'b1;
        end
        default: begin
          // unused modes: drop the byte
        end
      endcase
    end
  end

  assign fire      = a_valid_q && (!emit || out_free);
  assign a_done    = fire && done;
  assign s_axis_tready_o = !a_valid_q || a_done;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (fire && emit) begin
      if (eor) begin
        col_d = '0;
        row_d = eoi ? '0 : row_next[COORD_BITS-1:0];
      end else begin
        col_d = col_next[COORD_BITS-1:0];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_GRAY8;
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PIXEL_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: begin
          // no register here
        end
      endcase
    end
  end

  // Work register and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_pos_q   <= '0;
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      pend_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (fire) begin
        slot_q <= slot_d;
        pend_q <= pend_d;
      end
      if (in_accept) begin
        a_valid_q <= 1'b1;
        a_pos_q   <= '0;
      end else if (a_done) begin
        a_valid_q <= 1'b0;
      end else if (fire) begin
        a_pos_q <= a_pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_cmd_q   <= s_axis_tuser_i;
      a_byte_q  <= s_axis_tdata_i[7:0];
      a_pidx_q  <= s_axis_tdata_i[15:8];
      a_entry_q <= {s_axis_tdata_i[31:24], s_axis_tdata_i[47:40], s_axis_tdata_i[63:56]};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (out_free) begin
      o_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && emit) begin
      o_pal_q  <= pix_pal;
      o_pix_q  <= pix;
      o_eor_q  <= eor;
      o_eoi_q  <= eoi;
      o_last_q <= done;
    end
  end

  tsr_palette #(
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (fire && (a_cmd_q == CMD_PALETTE)),
    .wr_idx_i  (a_pidx_q),
    .wr_data_i (a_entry_q),
    .rd_en_i   (fire && emit && pix_pal),
    .rd_idx_i  (pal_rd_idx),
    .rd_data_o (pal_data)
  );

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = o_pal_q ? {CHAN_FULL, pal_data[7:0], pal_data[15:8], pal_data[23:16]}
                                   : o_pix_q;
  assign m_axis_tuser_o  = {o_eoi_q, o_eor_q};
  assign m_axis_tlast_o  = o_last_q;

endmodule

`default_nettype wire

// ===== verif/rgba_stream_checker.sv =====
// Checker for the TIFF sample unit: predicts the RGBA8 pixel stream and compares it.
`timescale 1ns / 1ps

module rgba_stream_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  input  logic                           s_ready_i,
  input  logic [tsr_pkg::IN_DATA_W-1:0]  s_data_i,
  input  logic                           s_cmd_i,
  input  logic                           m_valid_i,
  input  logic                           m_ready_i,
  input  logic [tsr_pkg::OUT_DATA_W-1:0] m_data_i,
  input  logic [tsr_pkg::OUT_USER_W-1:0] m_user_i,
  input  logic                           m_last_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);
  import tsr_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              end_of_row;
    logic              end_of_image;
    logic              last_in_run;
  } pixel_t;

  localparam int unsigned COORD_MASK = (1 << COORD_BITS_DEF) - 1;

  logic [MODE_W-1:0]  mode_q;
  int unsigned        width_q;
  int unsigned        height_q;
  int unsigned        column_q;
  int unsigned        row_q;
  int unsigned        slot_q;
  logic [ENTRY_W-1:0] held_channels;
  logic [ENTRY_W-1:0] colour_map [PALETTE_DEPTH_DEF];
  pixel_t             expected_pixels [$];
  int unsigned        mismatches;
  int unsigned        pixels_seen;

  // Build one pixel and advance the column and row counters past it.
  function automatic pixel_t next_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                        input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
    pixel_t p;
    p.red          = r;
    p.green        = g;
    p.blue         = b;
    p.alpha        = a;
    p.end_of_row   = (column_q + 1) >= width_q;
    p.end_of_image = p.end_of_row && ((row_q + 1) >= height_q);
    p.last_in_run  = 1'b0;
    if (p.end_of_row) begin
      column_q = 0;
      row_q    = p.end_of_image ? 0 : ((row_q + 1) & COORD_MASK);
    end else begin
      column_q = (column_q + 1) & COORD_MASK;
    end
    return p;
  endfunction

  function automatic pixel_t entry_pixel(input logic [PIDX_W-1:0] idx);
    logic [ENTRY_W-1:0] e;
    e = colour_map[idx];
    return next_pixel(e[23:16], e[15:8], e[7:0], CHAN_FULL);
  endfunction

  task automatic decode_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
    logic [SAMPLE_W-1:0] smp;
    logic [CHAN_W-1:0]   level;
    pixel_t              run [$];
    pixel_t              tail;
    int                  bit_pos;
    int unsigned         top_slot;
    smp = data[7:0];
    if (cmd == CMD_PALETTE) begin
      // keep only the high byte of each 16-bit colour
      colour_map[data[15:8]] = {data[31:24], data[47:40], data[63:56]};
    end else begin
      case (mode_q)
        MODE_BILEVEL: begin
          for (bit_pos = 7; bit_pos >= 0; bit_pos--) begin
            level = smp[bit_pos] ? CHAN_FULL : CHAN_EMPTY;
            tail  = next_pixel(level, level, level, CHAN_FULL);
            run   = {run, tail};
            // drop padding bits past the row end
            if (tail.end_of_row) break;
          end
        end
        MODE_GRAY8: begin
          tail = next_pixel(smp, smp, smp, CHAN_FULL);
          run  = {run, tail};
        end
        MODE_RGB, MODE_RGBA: begin
          top_slot = (mode_q == MODE_RGB) ? 2 : 3;
          if (slot_q >= top_slot) begin
            if (mode_q == MODE_RGB) begin
              tail = next_pixel(held_channels[23:16], held_channels[15:8], smp, CHAN_FULL);
            end else begin
              tail = next_pixel(held_channels[23:16], held_channels[15:8],
                                held_channels[7:0], smp);
            end
            run    = {run, tail};
            slot_q = 0;
          end else begin
            case (slot_q)
              0:       held_channels[23:16] = smp;
              1:       held_channels[15:8]  = smp;
              default: held_channels[7:0]   = smp;
            endcase
            slot_q = slot_q + 1;
          end
        end
        MODE_PALETTE4: begin
          tail = entry_pixel({4'd0, smp[7:4]});
          run  = {run, tail};
          // a trailing nibble past the row end is dropped
          if (!tail.end_of_row) begin
            tail = entry_pixel({4'd0, smp[3:0]});
            run  = {run, tail};
          end
        end
        MODE_PALETTE8: begin
          tail = entry_pixel(smp);
          run  = {run, tail};
        end
        default: ;
      endcase
      if (run.size() > 0) run[run.size() - 1].last_in_run = 1'b1;
      expected_pixels = {expected_pixels, run};
    end
  endtask

  task automatic check_pixel();
    pixel_t got;
    pixel_t want;
    got.red          = m_data_i[7:0];
    got.green        = m_data_i[15:8];
    got.blue         = m_data_i[23:16];
    got.alpha        = m_data_i[31:24];
    got.end_of_row   = m_user_i[0];
    got.end_of_image = m_user_i[1];
    got.last_in_run  = m_last_i;
    if (expected_pixels.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t: pixel %0d arrived with none outstanding: rgba %h %h %h %h flags %b%b%b",
                 $time, pixels_seen, got.red, got.green, got.blue, got.alpha,
                 got.end_of_row, got.end_of_image, got.last_in_run);
      end
      mismatches++;
    end else begin
      want = expected_pixels.pop_front();
      if (got != want) begin
        if (mismatches < 10) begin
          $display("%0t: pixel %0d expected rgba %h %h %h %h eor %b eoi %b last %b",
                   $time, pixels_seen, want.red, want.green, want.blue, want.alpha,
                   want.end_of_row, want.end_of_image, want.last_in_run);
          $display("%0t: pixel %0d actual   rgba %h %h %h %h eor %b eoi %b last %b",
                   $time, pixels_seen, got.red, got.green, got.blue, got.alpha,
                   got.end_of_row, got.end_of_image, got.last_in_run);
        end
        mismatches++;
      end
    end
    pixels_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        = MODE_GRAY8;
      width_q       = 1;
      height_q      = 1;
      column_q      = 0;
      row_q         = 0;
      slot_q        = 0;
      held_channels = '0;
      mismatches    = 0;
      pixels_seen   = 0;
      expected_pixels.delete();
    end else begin
      // results leave before this edge's item can have produced any
      if (m_valid_i && m_ready_i) check_pixel();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PIXEL_MODE:   mode_q   = cfg_data_i[MODE_W-1:0];
          CFG_IMAGE_WIDTH:  width_q  = cfg_data_i;
          CFG_IMAGE_HEIGHT: height_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) decode_item(s_cmd_i, s_data_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_pixels.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top: drives samples, palette loads and register writes into the unit.
`timescale 1ns / 1ps

module tb;
  import tsr_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 430;
  localparam int unsigned HOLD_AFTER    = 120;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned IDLE_LIMIT    = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = CMD_SAMPLE;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PIXEL_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int unsigned           mismatch_count;
  int unsigned           pending;
  logic                  sender_calm = 1'b0;
  bit                    palette_loaded [PALETTE_DEPTH_DEF];
  logic [PIDX_W-1:0]     loaded_indices [$];

  tiff_samples_to_rgba8_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  rgba_stream_checker pixel_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_valid_i        (s_tvalid),
    .s_ready_i        (s_tready),
    .s_data_i         (s_tdata),
    .s_cmd_i          (s_tuser),
    .m_valid_i        (m_tvalid),
    .m_ready_i        (m_tready),
    .m_data_i         (m_tdata),
    .m_user_i         (m_tuser),
    .m_last_i         (m_tlast),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [IN_DATA_W-1:0] pack_item(
      input logic [SAMPLE_W-1:0] smp, input logic [PIDX_W-1:0] idx,
      input logic [PCOL_W-1:0] r, input logic [PCOL_W-1:0] g, input logic [PCOL_W-1:0] b);
    return {b, g, r, idx, smp};
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim(input int unsigned usual_max);
    case ($urandom_range(0, 9))
      0:       return DIM_W'(1);
      1:       return '1;
      2:       return DIM_W'($urandom_range(1, 65535));
      default: return DIM_W'($urandom_range(1, usual_max));
    endcase
  endfunction

  // Palette8 bytes only ever point at entries already loaded.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [MODE_W-1:0] mode);
    logic [SAMPLE_W-1:0] smp;
    smp = SAMPLE_W'($urandom);
    if (mode == MODE_PALETTE8 && !palette_loaded[smp]) begin
      smp = loaded_indices[$urandom_range(0, loaded_indices.size() - 1)];
    end
    return smp;
  endfunction

  // Entered and left at a falling edge; valid stays up when the next item follows at once.
  task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    send_item(CMD_SAMPLE, pack_item(smp, PIDX_W'($urandom), PCOL_W'($urandom),
                                    PCOL_W'($urandom), PCOL_W'($urandom)));
  endtask

  task automatic send_colour(input logic [PIDX_W-1:0] idx, input logic [PCOL_W-1:0] r,
                             input logic [PCOL_W-1:0] g, input logic [PCOL_W-1:0] b);
    if (!palette_loaded[idx]) begin
      palette_loaded[idx] = 1'b1;
      loaded_indices      = {loaded_indices, idx};
    end
    send_item(CMD_PALETTE, pack_item(SAMPLE_W'($urandom), idx, r, g, b));
  endtask

  // Drain every expected pixel, then allow for items still in the work register.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [DIM_W-1:0] width,
                           input logic [DIM_W-1:0] height);
    settle();
    set_register(CFG_PIXEL_MODE, {{(CFG_DATA_W - MODE_W){1'b0}}, mode});
    set_register(CFG_IMAGE_WIDTH, width);
    set_register(CFG_IMAGE_HEIGHT, height);
  endtask

  initial begin : receiver
    int unsigned hold_left;
    int unsigned taken;
    logic        calm;
    hold_left = 0;
    taken     = 0;
    calm      = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        taken++;
        if (taken % 32 == 0) calm = ($urandom_range(0, 2) == 0);
        hold_left = calm ? 0 : $urandom_range(0, 6);
        // long hold-off so the unit fills up and stalls its input
        if (taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tiff_samples_to_rgba8_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [MODE_W-1:0] modes [6];
    logic [MODE_W-1:0] mode;
    int unsigned       sent;
    int unsigned       burst;
    int unsigned       k;
    modes = '{MODE_BILEVEL, MODE_GRAY8, MODE_RGB, MODE_RGBA, MODE_PALETTE4, MODE_PALETTE8};
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bilevel: rows of three end mid-byte, so padding bits are dropped
    configure(MODE_BILEVEL, 3, 2);
    send_sample(8'hFF);
    send_sample(8'h00);
    send_sample(8'hA5);
    send_sample(8'h80);
    configure(MODE_GRAY8, '1, '1);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_colour(8'h00, 16'hFFFF, 16'h0000, 16'h80FF);
    send_colour(8'h0F, 16'h00FF, 16'hFF00, 16'hFFFF);
    send_colour(8'hFF, 16'h7F01, 16'h0180, 16'hC3A5);
    // odd width: the low nibble of the second byte falls past the row end
    configure(MODE_PALETTE4, 3, 1);
    send_sample(8'h0F);
    send_sample(8'hF0);
    configure(MODE_PALETTE8, 1, 1);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'h0F);
    configure(MODE_RGBA, 2, 1);
    send_sample(8'h11);
    send_sample(8'h22);
    send_sample(8'h33);
    send_sample(8'h44);
    send_sample(8'h55);
    send_sample(8'h66);
    send_sample(8'h77);
    // three channels left over from rgba: the next rgb byte lands as blue
    configure(MODE_RGB, 2, 1);
    send_sample(8'h88);
    send_sample(8'h01);
    send_sample(8'h02);
    send_sample(8'h03);

    // load every entry a palette4 byte can reach
    for (k = 0; k < 16; k++) begin
      send_colour(PIDX_W'(k), PCOL_W'($urandom), PCOL_W'($urandom), PCOL_W'($urandom));
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = modes[$urandom_range(0, 5)];
      configure(mode, pick_dim(12), pick_dim(6));
      sender_calm = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(10, 40);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0) begin
          send_colour(PIDX_W'($urandom), PCOL_W'($urandom), PCOL_W'($urandom),
                      PCOL_W'($urandom));
        end else begin
          send_sample(pick_sample(mode));
        end
        sent++;
      end
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("tiff_samples_to_rgba8_unit: match");
    end else begin
      $display("tiff_samples_to_rgba8_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tsr_pkg.sv
design/tsr_palette.sv
design/tiff_samples_to_rgba8_unit.sv
verif/rgba_stream_checker.sv
verif/tb.sv
